// ===== design/mavw_pkg.sv =====
package mavw_pkg;

	localparam int unsigned MAX_WINDOW_DEF = 16;
	localparam int unsigned WIN_LEN_W = 5;
	localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 5'd16;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned GOOD_W = 8;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [GOOD_W-1:0] good_count;
	} mavw_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] average;
		logic no_data;
	} mavw_out_t;

endpackage

// ===== design/moving_average_window_unit.sv =====
// Moving-average window over signed 16-bit samples. Each accepted beat writes its sample into
// a ring of MAX_WINDOW entries, advances the write index (wrapping at the end of the window set
// by cfg_wdata) and returns the mean of the first min(good_count, window) ring entries,
// truncated toward zero; a good_count of zero returns 0 with no_data set. A beat with no
// data skips the adder and the divider. The datapath is one adder that sums the ring one
// entry per cycle, followed by a restoring divider that makes one quotient bit per cycle.
// A new item is taken while the previous result waits at the output register. Writing the
// window register also returns the write index to slot zero; write it only while the block
// is idle.
module moving_average_window_unit
	import mavw_pkg::*;
#(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  mavw_in_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output mavw_out_t            rsp,
	input  logic                 cfg_we,
	input  logic [WIN_LEN_W-1:0] cfg_wdata
);

	localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int unsigned SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int unsigned STEP_W = $clog2(SUM_W + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t                     state_q;
	logic [WIN_LEN_W-1:0]       win_len_q;
	logic [IDX_W-1:0]           widx_q;
	logic signed [SAMPLE_W-1:0] ring_q [MAX_WINDOW];
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           rd_q;
	logic signed [SUM_W-1:0]    acc_q;
	logic [SUM_W-1:0]           quo_q;
	logic [CNT_W-1:0]           rem_q;
	logic [STEP_W-1:0]          step_q;
	logic                       neg_q;
	logic                       nodata_q;
	logic                       rsp_valid_q;
	mavw_out_t                  rsp_q;

	logic [CNT_W-1:0]           win;
	logic [CNT_W-1:0]           count;
	logic                       accept;
	logic signed [SUM_W-1:0]    sum_next;
	logic [SUM_W-1:0]           sum_mag;
	logic [CNT_W:0]             rem_sh;
	logic [CNT_W+1:0]           diff;
	logic [SUM_W-1:0]           quo_neg;
	logic                       out_free;

	always_comb begin
		if (win_len_q == '0) begin
			win = CNT_W'(1);
		end else if (int'(win_len_q) > int'(MAX_WINDOW)) begin
			win = CNT_W'(MAX_WINDOW);
		end else begin
			win = CNT_W'(win_len_q);
		end
		if (int'(req.good_count) >= int'(win)) begin
			count = win;
		end else begin
			count = CNT_W'(req.good_count);
		end
	end

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign sum_next  = acc_q + SUM_W'(ring_q[rd_q[IDX_W-1:0]]);
	assign sum_mag   = sum_next[SUM_W-1] ? (~sum_next + 1'b1) : sum_next;
	assign rem_sh    = {rem_q, quo_q[SUM_W-1]};
	assign diff      = {1'b0, rem_sh} - {2'b00, cnt_q};
	assign quo_neg   = ~quo_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(MAX_WINDOW); i++) begin
				ring_q[i] <= '0;
			end
		end else if (accept) begin
			ring_q[widx_q] <= req.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_len_q   <= WIN_LEN_RESET;
			widx_q      <= '0;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
			rd_q        <= '0;
			acc_q       <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			neg_q       <= 1'b0;
			nodata_q    <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != ST_FINISH) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= count;
						rd_q  <= '0;
						acc_q <= '0;
						if (count == '0) begin
							nodata_q <= 1'b1;
							neg_q    <= 1'b0;
							quo_q    <= '0;
							state_q  <= ST_FINISH;
						end else begin
							nodata_q <= 1'b0;
							state_q  <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					acc_q <= sum_next;
					rd_q  <= rd_q + 1'b1;
					if (rd_q == cnt_q - 1'b1) begin
						quo_q   <= sum_mag;
						neg_q   <= sum_next[SUM_W-1];
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!diff[CNT_W+1]) begin
						rem_q <= diff[CNT_W-1:0];
						quo_q <= {quo_q[SUM_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[CNT_W-1:0];
						quo_q <= {quo_q[SUM_W-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						rsp_q.average <= neg_q ? quo_neg[SAMPLE_W-1:0] : quo_q[SAMPLE_W-1:0];
						rsp_q.no_data <= nodata_q;
						rsp_valid_q   <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				win_len_q <= cfg_wdata;
				widx_q    <= '0;
			end else if (accept) begin
				if (int'(widx_q) >= int'(win) - 1) begin
					widx_q <= '0;
				end else begin
					widx_q <= widx_q + 1'b1;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== design/mavw_checker.sv =====
module mavw_checker
	import mavw_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input mavw_in_t             req,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input mavw_out_t            rsp,
	input logic                 cfg_we
);

	// A held result beat must not change.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// The unit works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready high right after an accepted beat");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_ready) |-> $past(req_valid && req_ready))
		else $error("ready dropped without an accepted beat");

	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.no_data |-> rsp.average == '0)
		else $error("no_data result with nonzero average");

	// The window register is only written while the unit is idle and empty.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> req_ready && !rsp_valid)
		else $error("window written while an item was in flight");

endmodule

bind moving_average_window_unit mavw_checker u_mavw_checker (.*);
